// ===== sv/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Contiguous first-fit allocator package
// Shared constants, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int NumBlocksDefault = 256;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  localparam logic [1:0] StatusDone   = 2'd0;
  localparam logic [1:0] StatusNoRoom = 2'd1;
  localparam logic [1:0] StatusBad    = 2'd2;

  typedef struct packed {
    logic accept;
    logic set_bad;
    logic set_no_room;
    logic mark_free_init;
    logic mark_alloc_init;
    logic scan_init;
    logic scan_run;
    logic mark_run;
    logic clear_run;
    logic push_out;
  } dp_cmd_t;

  typedef struct packed {
    logic req_bad;
    logic req_free;
    logic scan_found;
    logic scan_exhausted;
    logic mark_last;
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/cfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the map clear, request check, first-fit scan, range marking and
// result hand-off by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module cfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfa_pkg::dp_status_t status_i,
  output cfa_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    StClear  = 6'b000001,
    StIdle   = 6'b000010,
    StCheck  = 6'b000100,
    StScan   = 6'b001000,
    StMark   = 6'b010000,
    StFinish = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_run = 1'b1;
        if (status_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StCheck;
        end
      end
      StCheck: begin
        if (status_i.req_bad) begin
          cmd_o.set_bad = 1'b1;
          state_d       = StFinish;
        end else if (status_i.req_free) begin
          cmd_o.mark_free_init = 1'b1;
          state_d              = StMark;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_found) begin
          cmd_o.mark_alloc_init = 1'b1;
          state_d               = StMark;
        end else if (status_i.scan_exhausted) begin
          cmd_o.set_no_room = 1'b1;
          state_d           = StFinish;
        end
      end
      StMark: begin
        cmd_o.mark_run = 1'b1;
        if (status_i.mark_last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (status_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

endmodule

// ===== sv/cfa_datapath.sv =====
// ----------------------------------------------------------------------------
// Allocator datapath
// Holds the block map memory, the request, the scan and mark pointers, the
// run tracker and the output register.
// ----------------------------------------------------------------------------
module cfa_datapath #(
  parameter int NumBlocks = cfa_pkg::NumBlocksDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfa_pkg::dp_cmd_t    cmd_i,
  output cfa_pkg::dp_status_t status_o,
  input  logic                req_type_i,
  input  logic [8:0]          block_count_i,
  input  logic [7:0]          first_block_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o_field,
  output logic [7:0]          run_start_o
);

  localparam int AW = $clog2(NumBlocks);
  localparam int CW = $clog2(NumBlocks + 1);
  localparam int XW = ((CW > 9) ? CW : 9) + 1;
  localparam logic [XW-1:0] NumX     = XW'(NumBlocks);
  localparam logic [AW-1:0] LastAddr = AW'(NumBlocks - 1);

  logic map_q [NumBlocks];

  logic          req_type_q;
  logic [8:0]    req_count_q;
  logic [7:0]    req_first_q;

  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic          issue_done_q, issue_done_d;
  logic          eval_valid_q, eval_valid_d;
  logic [AW-1:0] eval_addr_q, eval_addr_d;
  logic          rd_data_q;
  logic          rd_en;
  logic [CW-1:0] run_len_q, run_len_d;
  logic [AW-1:0] run_begin_q, run_begin_d;
  logic [AW-1:0] begin_now;

  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] remain_q, remain_d;
  logic          mark_val_q, mark_val_d;
  logic          wr_en;
  logic          wr_val;

  logic [1:0]    res_status_q, res_status_d;
  logic [AW-1:0] res_start_q, res_start_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q;
  logic [7:0]    out_start_q;

  logic [XW-1:0] count_x;
  logic [XW-1:0] first_x;
  logic          hit;

  assign count_x   = XW'(req_count_q);
  assign first_x   = XW'(req_first_q);
  assign begin_now = (run_len_q == '0) ? eval_addr_q : run_begin_q;
  assign hit       = eval_valid_q && !rd_data_q &&
                     ((XW'(run_len_q) + XW'(1)) == count_x);

  always_comb begin
    status_o.req_free       = (req_type_q == cfa_pkg::ReqFree);
    if (req_type_q == cfa_pkg::ReqFree) begin
      status_o.req_bad = (req_count_q == '0) || ((first_x + count_x) > NumX);
    end else begin
      status_o.req_bad = (req_count_q == '0) || (count_x > NumX);
    end
    status_o.scan_found     = hit;
    status_o.scan_exhausted = issue_done_q && !eval_valid_q;
    status_o.mark_last      = (remain_q == CW'(1));
    status_o.clear_last     = (wr_ptr_q == LastAddr);
    status_o.out_free       = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    issue_done_d = issue_done_q;
    eval_valid_d = eval_valid_q;
    eval_addr_d  = eval_addr_q;
    run_len_d    = run_len_q;
    run_begin_d  = run_begin_q;
    rd_en        = 1'b0;
    if (cmd_i.scan_init) begin
      rd_ptr_d     = '0;
      issue_done_d = 1'b0;
      eval_valid_d = 1'b0;
      run_len_d    = '0;
    end else if (cmd_i.scan_run) begin
      if (!issue_done_q) begin
        rd_en        = 1'b1;
        eval_valid_d = 1'b1;
        eval_addr_d  = rd_ptr_q;
        if (rd_ptr_q == LastAddr) begin
          issue_done_d = 1'b1;
        end else begin
          rd_ptr_d = rd_ptr_q + AW'(1);
        end
      end else begin
        eval_valid_d = 1'b0;
      end
      if (eval_valid_q) begin
        if (!rd_data_q) begin
          run_len_d   = run_len_q + CW'(1);
          run_begin_d = begin_now;
        end else begin
          run_len_d = '0;
        end
      end
    end
  end

  always_comb begin
    wr_ptr_d     = wr_ptr_q;
    remain_d     = remain_q;
    mark_val_d   = mark_val_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    wr_en        = cmd_i.clear_run | cmd_i.mark_run;
    wr_val       = cmd_i.mark_run & mark_val_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + AW'(1);
      remain_d = remain_q - CW'(1);
    end
    if (cmd_i.mark_free_init) begin
      wr_ptr_d     = AW'(req_first_q);
      remain_d     = CW'(req_count_q);
      mark_val_d   = 1'b0;
      res_status_d = cfa_pkg::StatusDone;
      res_start_d  = '0;
    end
    if (cmd_i.mark_alloc_init) begin
      wr_ptr_d     = begin_now;
      remain_d     = CW'(req_count_q);
      mark_val_d   = 1'b1;
      res_status_d = cfa_pkg::StatusDone;
      res_start_d  = begin_now;
    end
    if (cmd_i.set_bad) begin
      res_status_d = cfa_pkg::StatusBad;
      res_start_d  = '0;
    end
    if (cmd_i.set_no_room) begin
      res_status_d = cfa_pkg::StatusNoRoom;
      res_start_d  = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.push_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_q[wr_ptr_q] <= wr_val;
    end
    if (rd_en) begin
      rd_data_q <= map_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_done_q <= 1'b0;
      eval_valid_q <= 1'b0;
      wr_ptr_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      issue_done_q <= issue_done_d;
      eval_valid_q <= eval_valid_d;
      wr_ptr_q     <= wr_ptr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_type_q  <= req_type_i;
      req_count_q <= block_count_i;
      req_first_q <= first_block_i;
    end
    rd_ptr_q     <= rd_ptr_d;
    eval_addr_q  <= eval_addr_d;
    run_len_q    <= run_len_d;
    run_begin_q  <= run_begin_d;
    remain_q     <= remain_d;
    mark_val_q   <= mark_val_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    if (cmd_i.push_out) begin
      out_status_q <= res_status_q;
      out_start_q  <= 8'(res_start_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o_field = out_status_q;
  assign run_start_o    = out_start_q;

endmodule

// ===== sv/contiguous_first_fit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Contiguous first-fit block allocator
// Allocates the lowest-starting run of free blocks from a one-bit-per-block
// map, and frees block ranges, one transaction at a time.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   req_type_i, block_count_i, first_block_i
// result    out        out_valid_o / out_stall_i status_o, run_start_o
//
// After reset a clearing pass writes every map entry free, with in_stall_o
// high. An allocate runs the check, scan, mark and finish steps (no mark on
// no room); the map memory's single read port walks one block per cycle,
// its write port marks one. A free runs the check, mark and finish steps; a
// bad request goes from the check step straight to the finish step.
// A new request is taken while the previous result waits in the output
// register; a stalled output holds the next result in the finish step.
// ----------------------------------------------------------------------------
module contiguous_first_fit_allocator_top #(
  parameter int NUM_BLOCKS = cfa_pkg::NumBlocksDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [8:0] block_count_i,
  input  logic [7:0] first_block_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] run_start_o
);

  cfa_pkg::dp_cmd_t    dp_cmd;
  cfa_pkg::dp_status_t dp_status;

  cfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  cfa_datapath #(
    .NumBlocks (NUM_BLOCKS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .req_type_i     (req_type_i),
    .block_count_i  (block_count_i),
    .first_block_i  (first_block_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o_field (status_o),
    .run_start_o    (run_start_o)
  );

endmodule

// ===== sv/cfa_checker.sv =====
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the top-level ports for result coding and transaction ordering.
// ----------------------------------------------------------------------------
module cfa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] run_start_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(run_start_o))
    else $error("Stalled result changed or dropped.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == cfa_pkg::StatusDone) ||
      (status_o == cfa_pkg::StatusNoRoom) || (status_o == cfa_pkg::StatusBad))
    else $error("Result carries an undefined status.");

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != cfa_pkg::StatusDone) |-> run_start_o == 8'd0)
    else $error("Failed request reports a nonzero start block.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Request taken while the previous one is still in progress.");

endmodule

bind contiguous_first_fit_allocator_top cfa_checker u_cfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .run_start_o (run_start_o)
);

// ===== tb/sv/contiguous_first_fit_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// Contiguous first-fit allocator testbench
// Drives allocate and free transactions through the request channel with
// random idle gaps and random result stalls. A predictor keeps its own
// block map and computes the expected status and start block of every
// accepted request. Each accepted result is compared with the oldest
// expected one. Directed cases cover the bad, no-room and boundary requests,
// followed by mostly well-formed random allocate and free sequences.
// ----------------------------------------------------------------------------
module contiguous_first_fit_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumBlocks = cfa_pkg::NumBlocksDefault;
  localparam int RandomReqs = 600;

  typedef struct {
    logic       req_type;
    logic [8:0] block_count;
    logic [7:0] first_block;
    int         gap;
  } block_req_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] run_start;
  } alloc_result_t;

  typedef struct {
    int first;
    int count;
  } alloc_run_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       req_type_i = cfa_pkg::ReqAlloc;
  logic [8:0] block_count_i = '0;
  logic [7:0] first_block_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] run_start_o;

  block_req_t         pending_reqs[$];
  alloc_result_t      expected_results[$];
  alloc_run_t         live_runs[$];
  bit [NumBlocks-1:0] gen_map;
  bit [NumBlocks-1:0] pred_map;
  bit                 in_quiet;
  bit                 out_quiet;
  int                 gap_left;
  int                 stall_left;
  int                 mismatch_count;
  block_req_t         drive_req;
  alloc_result_t      pred_res;
  alloc_result_t      want_res;

  contiguous_first_fit_allocator_top #(
    .NUM_BLOCKS(NumBlocks)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .block_count_i(block_count_i),
    .first_block_i(first_block_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .run_start_o  (run_start_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void serve_request(input bit [NumBlocks-1:0] map_in,
                                        input logic rtype,
                                        input logic [8:0] count,
                                        input logic [7:0] first,
                                        output bit [NumBlocks-1:0] map_out,
                                        output alloc_result_t res);
    int run_len;
    int run_begin;
    int cnt;
    int lo;
    bit found;
    map_out = map_in;
    res.status = cfa_pkg::StatusDone;
    res.run_start = '0;
    run_len = 0;
    run_begin = 0;
    found = 1'b0;
    cnt = int'(count);
    lo = int'(first);
    if (rtype == cfa_pkg::ReqAlloc) begin
      if (cnt == 0 || cnt > NumBlocks) begin
        res.status = cfa_pkg::StatusBad;
        return;
      end
      for (int i = 0; i < NumBlocks; i++) begin
        if (!found) begin
          if (!map_in[i]) begin
            if (run_len == 0) run_begin = i;
            run_len++;
            if (run_len == cnt) found = 1'b1;
          end else begin
            run_len = 0;
          end
        end
      end
      if (!found) begin
        res.status = cfa_pkg::StatusNoRoom;
        return;
      end
      for (int i = 0; i < NumBlocks; i++) begin
        if (i >= run_begin && i < run_begin + cnt) map_out[i] = 1'b1;
      end
      res.run_start = run_begin[7:0];
    end else begin
      if (cnt == 0 || lo + cnt > NumBlocks) begin
        res.status = cfa_pkg::StatusBad;
        return;
      end
      for (int i = 0; i < NumBlocks; i++) begin
        if (i >= lo && i < lo + cnt) map_out[i] = 1'b0;
      end
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  task automatic queue_request(input logic rtype, input int count, input int first);
    block_req_t req;
    alloc_result_t res;
    alloc_run_t run;
    req.req_type = rtype;
    req.block_count = count[8:0];
    req.first_block = first[7:0];
    if ($urandom_range(0, 49) == 0) in_quiet = ~in_quiet;
    req.gap = in_quiet ? 0 : gap_len();
    serve_request(gen_map, req.req_type, req.block_count, req.first_block, gen_map, res);
    if (rtype == cfa_pkg::ReqAlloc && res.status == cfa_pkg::StatusDone) begin
      run.first = int'(res.run_start);
      run.count = count;
      live_runs.push_back(run);
    end
    pending_reqs.push_back(req);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int pick_alloc_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(1, 40);
    return $urandom_range(1, NumBlocks);
  endfunction

  initial begin : stimulus
    alloc_run_t run;
    int idx;
    int r;
    int count;
    gen_map = '0;
    in_quiet = 1'b0;
    queue_request(cfa_pkg::ReqAlloc, 0, 0);
    queue_request(cfa_pkg::ReqFree, 0, 255);
    queue_request(cfa_pkg::ReqAlloc, 257, 0);
    queue_request(cfa_pkg::ReqAlloc, 511, 255);
    queue_request(cfa_pkg::ReqAlloc, 256, 0);
    queue_request(cfa_pkg::ReqAlloc, 1, 0);
    queue_request(cfa_pkg::ReqFree, 2, 255);
    queue_request(cfa_pkg::ReqFree, 255, 1);
    queue_request(cfa_pkg::ReqAlloc, 255, 0);
    queue_request(cfa_pkg::ReqAlloc, 1, 0);
    queue_request(cfa_pkg::ReqFree, 256, 0);
    queue_request(cfa_pkg::ReqFree, 128, 128);
    queue_request(cfa_pkg::ReqAlloc, 3, 0);
    queue_request(cfa_pkg::ReqAlloc, 5, 0);
    queue_request(cfa_pkg::ReqAlloc, 2, 0);
    queue_request(cfa_pkg::ReqFree, 5, 3);
    queue_request(cfa_pkg::ReqAlloc, 6, 0);
    queue_request(cfa_pkg::ReqAlloc, 4, 0);
    queue_request(cfa_pkg::ReqAlloc, 1, 0);
    queue_request(cfa_pkg::ReqAlloc, 1, 0);
    queue_request(cfa_pkg::ReqFree, 256, 0);
    queue_request(cfa_pkg::ReqAlloc, 256, 170);
    queue_request(cfa_pkg::ReqFree, 256, 1);
    queue_request(cfa_pkg::ReqFree, 256, 0);
    live_runs.delete();

    for (int n = 0; n < RandomReqs; n++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        queue_request(cfa_pkg::ReqFree, NumBlocks, 0);
        live_runs.delete();
      end else if (r < 80 && r >= 45 && live_runs.size() != 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        if ($urandom_range(0, 4) == 0) begin
          count = $urandom_range(1, run.count);
          queue_request(cfa_pkg::ReqFree, count,
                        run.first + $urandom_range(0, run.count - count));
        end else begin
          queue_request(cfa_pkg::ReqFree, run.count, run.first);
        end
      end else if (r < 80) begin
        queue_request(cfa_pkg::ReqAlloc, pick_alloc_count(), $urandom_range(0, 255));
      end else if (r < 90) begin
        queue_request(cfa_pkg::ReqFree, $urandom_range(0, NumBlocks), $urandom_range(0, 255));
      end else begin
        queue_request(cfa_pkg::ReqAlloc, $urandom_range(0, 511), $urandom_range(0, 255));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        drive_req = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= drive_req.req_type;
        block_count_i <= drive_req.block_count;
        first_block_i <= drive_req.first_block;
        gap_left <= drive_req.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
      out_quiet <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i && $urandom_range(0, 29) == 0) out_quiet <= ~out_quiet;
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!out_quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_left <= gap_len();
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      serve_request(pred_map, req_type_i, block_count_i, first_block_i, pred_map, pred_res);
      expected_results.push_back(pred_res);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction status=%0d run_start=%0d",
                                  status_o, run_start_o));
      end else begin
        want_res = expected_results.pop_front();
        if (status_o !== want_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want_res.status));
        if (run_start_o !== want_res.run_start)
          report_mismatch($sformatf("run_start %0d, expected %0d",
                                    run_start_o, want_res.run_start));
      end
    end
  end

  initial begin
    pred_map = '0;
    mismatch_count = 0;
  end

endmodule
